@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the smooth radial cutoff block.
// No dependencies; the clock is clk_i and the active-low reset is rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked at every clock edge, reset included.
`define SRC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

@@ hw/rtl/src_pkg.sv @@
// Package of the smooth radial cutoff block: fixed-point constants, series tables and types.
// No dependencies; used by src_cfg, src_horner_step and smooth_radial_cutoff.
package src_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SH30      = 30 - FRAC_BITS;

  localparam logic [16:0] ONE_F    = 17'(1 << FRAC_BITS);
  localparam logic [16:0] HALF_F   = 17'(1 << (FRAC_BITS - 1));
  localparam logic [31:0] ONE30    = 32'h4000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] ROUND30  = 32'(1 << (SH30 - 1));
  localparam logic [31:0] SLOPE_LIM = 32'h8000_0000;

  localparam logic signed [25:0] VAL_MAX = 26'sd524287;
  localparam logic signed [25:0] VAL_MIN = -26'sd524288;

  localparam int unsigned HORNER_STEPS = 8;
  localparam int unsigned SIN_TERMS    = 7;

  // Divisors of the nested series and floor(2^32 / divisor).
  localparam logic [7:0] SIN_DIV [SIN_TERMS] = '{8'd210, 8'd156, 8'd110, 8'd72,
                                                 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_RECIP [SIN_TERMS] = '{32'd20452225, 32'd27531841,
                                                    32'd39045157, 32'd59652323,
                                                    32'd102261126, 32'd214748364,
                                                    32'd715827882};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd240, 8'd182, 8'd132, 8'd90,
                                                    8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{32'd17895697, 32'd23598721,
                                                       32'd32537631, 32'd47721858,
                                                       32'd76695844, 32'd143165576,
                                                       32'd357913941, 32'd2147483648};

  typedef enum logic [1:0] {
    CFG_COSINE_MODE = 2'd0,
    CFG_INV_CUTOFF  = 2'd1,
    CFG_POLY_GAMMA  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        cosine_mode;
    logic [20:0] inv_cutoff;
    logic [21:0] poly_gamma;
  } cfg_t;

  typedef struct packed {
    logic        mask;
    logic        upper;
    logic [30:0] t;
    logic [16:0] z;
    logic [16:0] z4;
    logic [28:0] gg;
  } side_t;

endpackage

@@ hw/rtl/src_cfg.sv @@
// Configuration register file of the smooth radial cutoff block.
// Depends on src_pkg for the register indices and the configuration struct.
module src_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [21:0]       cfg_data_i,
  output src_pkg::cfg_t     cfg_o
);

  src_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        src_pkg::CFG_COSINE_MODE: cfg_d.cosine_mode = cfg_data_i[0];
        src_pkg::CFG_INV_CUTOFF:  cfg_d.inv_cutoff  = cfg_data_i[20:0];
        src_pkg::CFG_POLY_GAMMA:  cfg_d.poly_gamma  = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cosine_mode <= 1'b1;
      cfg_q.inv_cutoff  <= 21'd65536;
      cfg_q.poly_gamma  <= 22'd327680;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hw/rtl/src_horner_step.sv @@
// One nested-series step for the cosine and sine lanes, three register stages deep.
// Depends on src_pkg for the divisor tables, the reciprocals and the sideband struct.
module src_horner_step #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [31:0]       t2_i,
  input  logic [31:0]       acc_c_i,
  input  logic [31:0]       acc_s_i,
  input  src_pkg::side_t    side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [31:0]       t2_o,
  output logic [31:0]       acc_c_o,
  output logic [31:0]       acc_s_o,
  output src_pkg::side_t    side_o
);

  localparam bit          HasSin = IDX < src_pkg::SIN_TERMS;
  localparam int unsigned SinIdx = HasSin ? IDX : 0;
  localparam logic [7:0]  CDiv   = src_pkg::COS_DIV[IDX];
  localparam logic [31:0] CRec   = src_pkg::COS_RECIP[IDX];
  localparam logic [7:0]  SDiv   = src_pkg::SIN_DIV[SinIdx];
  localparam logic [31:0] SRec   = src_pkg::SIN_RECIP[SinIdx];

  logic           va_q, vb_q, vc_q;
  logic           rdy_a, rdy_b, rdy_c;
  logic [31:0]    t2a_q, t2b_q, t2c_q;
  logic [31:0]    xca_d, xsa_d, xca_q, xsa_q, xcb_q, xsb_q;
  logic [31:0]    accsa_q, accsb_q;
  logic [63:0]    pcb_d, psb_d, pcb_q, psb_q;
  logic [31:0]    accc_d, accs_d, accc_q, accs_q;
  src_pkg::side_t sa_q, sb_q, sc_q;
  logic [62:0]    prod_c, prod_s;
  logic [31:0]    qc0, qs0, qc, qs;
  logic [32:0]    rc, rs;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_comb begin
    prod_c = 63'(t2_i) * 63'(acc_c_i[30:0]);
    prod_s = 63'(t2_i) * 63'(acc_s_i[30:0]);
    xca_d  = prod_c[61:30];
    xsa_d  = prod_s[61:30];
    pcb_d  = 64'(xca_q) * 64'(CRec);
    psb_d  = 64'(xsa_q) * 64'(SRec);
    qc0    = pcb_q[63:32];
    qs0    = psb_q[63:32];
    rc     = 33'(xcb_q) - 33'(qc0) * 33'(CDiv);
    rs     = 33'(xsb_q) - 33'(qs0) * 33'(SDiv);
    qc     = (rc >= 33'(CDiv)) ? qc0 + 32'd1 : qc0;
    qs     = (rs >= 33'(SDiv)) ? qs0 + 32'd1 : qs0;
    accc_d = src_pkg::ONE30 - qc;
    accs_d = HasSin ? src_pkg::ONE30 - qs : accsb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      t2a_q   <= t2_i;
      xca_q   <= xca_d;
      xsa_q   <= xsa_d;
      accsa_q <= acc_s_i;
      sa_q    <= side_i;
    end
    if (rdy_b) begin
      t2b_q   <= t2a_q;
      xcb_q   <= xca_q;
      xsb_q   <= xsa_q;
      pcb_q   <= pcb_d;
      psb_q   <= psb_d;
      accsb_q <= accsa_q;
      sb_q    <= sa_q;
    end
    if (rdy_c) begin
      t2c_q  <= t2b_q;
      accc_q <= accc_d;
      accs_q <= accs_d;
      sc_q   <= sb_q;
    end
  end

  assign valid_o = vc_q;
  assign t2_o    = t2c_q;
  assign acc_c_o = accc_q;
  assign acc_s_o = accs_q;
  assign side_o  = sc_q;

endmodule

@@ hw/rtl/smooth_radial_cutoff.sv @@
// Smooth radial cutoff: cosine or polynomial cutoff value and slope of one pair distance.
// Depends on src_pkg, src_cfg and src_horner_step.
//
// The block accepts one transaction per clock cycle while the output is not stalled;
// each result passes through these stages in order: four stages form z, the angle
// and the powers of z, eight series steps of three stages each evaluate sine and cosine,
// and four stages finish value and slope, the last being the output register. Every
// stage holds its own valid bit and takes new data whenever it is empty or its successor
// moves, so a stall at the output fills empty stages before the input is held off.
// Configuration must only be written while no transaction is in flight.
module smooth_radial_cutoff (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [21:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [23:0]        distance_i,
  input  logic               inside_mask_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [19:0] cut_value_o,
  output logic signed [31:0] cut_slope_o
);

  localparam int unsigned NS = src_pkg::HORNER_STEPS;
  localparam int unsigned F  = src_pkg::FRAC_BITS;

  src_pkg::cfg_t cfg;

  src_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic v1_q, v2_q, v3_q, v4_q, vf1_q, vf2_q, vf3_q, vf4_q;
  logic r1, r2, r3, r4, rf1, rf2, rf3, rf4;

  logic [44:0] p1_d, p1_q;
  logic        m1_q, m2_q, m3_q;
  logic [16:0] z2s_d, z2s_q, z3_q;
  logic        up2_d, up2_q, up3_q;
  logic [29:0] u2_d, u2_q;
  logic [30:0] z30;
  logic [28:0] gg2_d, gg2_q, gg3_q;
  logic [44:0] ggp;
  logic [61:0] tp;
  logic [30:0] t3_d, t3_q;
  logic [33:0] zp2;
  logic [16:0] zsq3_d, zsq3_q;
  logic [61:0] t2p;
  logic [33:0] zp4;
  logic [31:0] t2_4_d, t2_4_q;
  src_pkg::side_t s4_d, s4_q;

  logic           h_valid [NS+1];
  logic           h_ready [NS+1];
  logic [31:0]    h_t2    [NS+1];
  logic [31:0]    h_accc  [NS+1];
  logic [31:0]    h_accs  [NS+1];
  src_pkg::side_t h_side  [NS+1];

  logic [30:0]    cf1_d, cf1_q;
  logic [61:0]    sp;
  logic [31:0]    sf1_d, sf1_q;
  logic [33:0]    zp5;
  logic [16:0]    z5f1_d, z5f1_q;
  src_pkg::side_t sdf1_q;

  logic [30:0]    sclamp;
  logic [62:0]    hp;
  logic [31:0]    hf2_d, hf2_q;
  logic [32:0]    vsum;
  logic [31:0]    vhalf;
  logic [16:0]    valc2_d, valc2_q, valc3_q;
  logic [33:0]    zp6;
  logic [16:0]    z6f2_d, z6f2_q;
  logic [39:0]    bp;
  logic [23:0]    bf2_d, bf2_q, bf3_q;
  logic [16:0]    dzf2_d, dzf2_q;
  logic [28:0]    gg_f2_q;
  logic           mf2_q, mf3_q;

  logic [51:0]    mcp;
  logic [21:0]    magc3_d, magc3_q;
  logic [38:0]    ap;
  logic [22:0]    af3_d, af3_q;
  logic [45:0]    mp;
  logic [29:0]    mf3_d, mf3v_q;

  logic [50:0]    mpp;
  logic [34:0]    magp, mag;
  logic [31:0]    mag_sat;
  logic signed [25:0] valp, valsel, valsat;
  logic signed [19:0] val4_d, val4_q;
  logic signed [31:0] slope4_d, slope4_q;

  // Ready chain: a stage loads when it is empty or its successor moves.
  assign rf4 = !vf4_q || out_ready_i;
  assign rf3 = !vf3_q || rf4;
  assign rf2 = !vf2_q || rf3;
  assign rf1 = !vf1_q || rf2;
  assign h_ready[NS] = rf1;
  assign r4  = !v4_q || h_ready[0];
  assign r3  = !v3_q || r4;
  assign r2  = !v2_q || r3;
  assign r1  = !v1_q || r2;
  assign in_ready_o = r1;

  always_comb begin
    p1_d   = 45'(distance_i) * 45'(cfg.inv_cutoff);

    z2s_d  = (p1_q[44:F] > 29'(src_pkg::ONE_F)) ? src_pkg::ONE_F : p1_q[F+16:F];
    up2_d  = z2s_d > src_pkg::HALF_F;
    z30    = 31'(z2s_d) << src_pkg::SH30;
    u2_d   = up2_d ? 30'(31'(src_pkg::ONE30) - z30) : z30[29:0];
    ggp    = 45'(cfg.poly_gamma) * 45'(23'(cfg.poly_gamma) + 23'(src_pkg::ONE_F));
    gg2_d  = ggp[F+28:F];

    tp     = 62'(u2_q) * 62'(src_pkg::PI_Q30);
    t3_d   = tp[60:30];
    zp2    = 34'(z2s_q) * 34'(z2s_q);
    zsq3_d = zp2[F+16:F];

    t2p    = 62'(t3_q) * 62'(t3_q);
    t2_4_d = t2p[61:30];
    zp4    = 34'(zsq3_q) * 34'(zsq3_q);
    s4_d.mask  = m3_q;
    s4_d.upper = up3_q;
    s4_d.t     = t3_q;
    s4_d.z     = z3_q;
    s4_d.z4    = zp4[F+16:F];
    s4_d.gg    = gg3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      vf3_q <= 1'b0;
      vf4_q <= 1'b0;
    end else begin
      if (r1)  v1_q  <= in_valid_i;
      if (r2)  v2_q  <= v1_q;
      if (r3)  v3_q  <= v2_q;
      if (r4)  v4_q  <= v3_q;
      if (rf1) vf1_q <= h_valid[NS];
      if (rf2) vf2_q <= vf1_q;
      if (rf3) vf3_q <= vf2_q;
      if (rf4) vf4_q <= vf3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      p1_q <= p1_d;
      m1_q <= inside_mask_i;
    end
    if (r2) begin
      z2s_q <= z2s_d;
      up2_q <= up2_d;
      u2_q  <= u2_d;
      gg2_q <= gg2_d;
      m2_q  <= m1_q;
    end
    if (r3) begin
      t3_q   <= t3_d;
      zsq3_q <= zsq3_d;
      z3_q   <= z2s_q;
      up3_q  <= up2_q;
      gg3_q  <= gg2_q;
      m3_q   <= m2_q;
    end
    if (r4) begin
      t2_4_q <= t2_4_d;
      s4_q   <= s4_d;
    end
  end

  assign h_valid[0] = v4_q;
  assign h_t2[0]    = t2_4_q;
  assign h_accc[0]  = src_pkg::ONE30;
  assign h_accs[0]  = src_pkg::ONE30;
  assign h_side[0]  = s4_q;

  for (genvar i = 0; i < NS; i++) begin : g_step
    src_horner_step #(.IDX(i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (h_valid[i]),
      .ready_o (h_ready[i]),
      .t2_i    (h_t2[i]),
      .acc_c_i (h_accc[i]),
      .acc_s_i (h_accs[i]),
      .side_i  (h_side[i]),
      .valid_o (h_valid[i+1]),
      .ready_i (h_ready[i+1]),
      .t2_o    (h_t2[i+1]),
      .acc_c_o (h_accc[i+1]),
      .acc_s_o (h_accs[i+1]),
      .side_o  (h_side[i+1])
    );
  end

  always_comb begin
    if (h_accc[NS][31]) begin
      cf1_d = '0;
    end else if (h_accc[NS] > src_pkg::ONE30) begin
      cf1_d = src_pkg::ONE30[30:0];
    end else begin
      cf1_d = h_accc[NS][30:0];
    end
    sp     = 62'(h_side[NS].t) * 62'(h_accs[NS][30:0]);
    sf1_d  = sp[61:30];
    zp5    = 34'(h_side[NS].z4) * 34'(h_side[NS].z);
    z5f1_d = zp5[F+16:F];

    sclamp  = (sf1_q > src_pkg::ONE30) ? src_pkg::ONE30[30:0] : sf1_q[30:0];
    hp      = 63'(src_pkg::PI_Q30) * 63'(sclamp);
    hf2_d   = hp[62:31];
    vsum    = sdf1_q.upper ? 33'(src_pkg::ONE30) - 33'(cf1_q)
                           : 33'(src_pkg::ONE30) + 33'(cf1_q);
    vhalf   = vsum[32:1];
    valc2_d = 17'((vhalf + src_pkg::ROUND30) >> src_pkg::SH30);
    zp6     = 34'(z5f1_q) * 34'(sdf1_q.z);
    z6f2_d  = zp6[F+16:F];
    bp      = 40'(23'(cfg.poly_gamma) + 23'(src_pkg::ONE_F)) * 40'(z5f1_q);
    bf2_d   = bp[F+23:F];
    dzf2_d  = sdf1_q.z4 - z5f1_q;

    mcp     = 52'(hf2_q) * 52'(cfg.inv_cutoff);
    magc3_d = mcp[51:30];
    ap      = 39'(cfg.poly_gamma) * 39'(z6f2_q);
    af3_d   = ap[F+22:F];
    mp      = 46'(gg_f2_q) * 46'(dzf2_q);
    mf3_d   = mp[F+29:F];

    mpp     = 51'(mf3v_q) * 51'(cfg.inv_cutoff);
    magp    = mpp[F+34:F];
    valp    = 26'sd65536 + $signed(26'(af3_q)) - $signed(26'(bf3_q));
    valsel  = cfg.cosine_mode ? $signed(26'(valc3_q)) : valp;
    mag     = cfg.cosine_mode ? 35'(magc3_q) : magp;
    if (valsel > src_pkg::VAL_MAX) begin
      valsat = src_pkg::VAL_MAX;
    end else if (valsel < src_pkg::VAL_MIN) begin
      valsat = src_pkg::VAL_MIN;
    end else begin
      valsat = valsel;
    end
    mag_sat = (mag > 35'(src_pkg::SLOPE_LIM)) ? src_pkg::SLOPE_LIM : mag[31:0];
    if (mf3_q) begin
      val4_d   = valsat[19:0];
      slope4_d = $signed(32'd0 - mag_sat);
    end else begin
      val4_d   = '0;
      slope4_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf1) begin
      cf1_q  <= cf1_d;
      sf1_q  <= sf1_d;
      z5f1_q <= z5f1_d;
      sdf1_q <= h_side[NS];
    end
    if (rf2) begin
      hf2_q   <= hf2_d;
      valc2_q <= valc2_d;
      z6f2_q  <= z6f2_d;
      bf2_q   <= bf2_d;
      dzf2_q  <= dzf2_d;
      gg_f2_q <= sdf1_q.gg;
      mf2_q   <= sdf1_q.mask;
    end
    if (rf3) begin
      magc3_q <= magc3_d;
      valc3_q <= valc2_q;
      af3_q   <= af3_d;
      bf3_q   <= bf2_q;
      mf3v_q  <= mf3_d;
      mf3_q   <= mf2_q;
    end
    if (rf4) begin
      val4_q   <= val4_d;
      slope4_q <= slope4_d;
    end
  end

  assign out_valid_o = vf4_q;
  assign cut_value_o = val4_q;
  assign cut_slope_o = slope4_q;

endmodule

@@ hw/rtl/src_checker.sv @@
// Port-level checker of the smooth radial cutoff block and its bind statement.
// Depends on assert_macros.svh and on the ports of smooth_radial_cutoff.
`include "assert_macros.svh"

module src_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [19:0] cut_value_o,
  input logic signed [31:0] cut_slope_o
);

  // A stalled result transaction keeps its payload.
  `SRC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(cut_value_o) && $stable(cut_slope_o))

  // The slope of a decreasing cutoff is never positive.
  `SRC_ASSERT(a_slope_sign, out_valid_o |-> cut_slope_o[31] || cut_slope_o == 32'sd0)

  // No result is offered while reset is held.
  `SRC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o)

  // Configuration writes are never back-pressured.
  `SRC_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_o)

endmodule

bind smooth_radial_cutoff src_checker u_src_checker (.*);
